@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/fcrb_pkg.sv @@
// ----------------------------------------------------------------------------
// fcrb_pkg
// Shared types, constants and helpers of the format converting blitter.
// ----------------------------------------------------------------------------
package fcrb_pkg;

   localparam int FMT_W  = 3;
   localparam int DIM_W  = 13;
   localparam int POS_W  = 12;
   localparam int CH_W   = 8;
   localparam int OFF_W  = 26;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

   // floor(x/3) == (x*683) >> 11 for x <= 765
   localparam logic [9:0] GRAY_RECIP = 10'd683;
   localparam int         GRAY_SHIFT = 11;

   localparam logic [CH_W-1:0] OPAQUE = 8'd255;

   // register indexes
   localparam logic [2:0] REG_SRC_FORMAT  = 3'd0;
   localparam logic [2:0] REG_DEST_FORMAT = 3'd1;
   localparam logic [2:0] REG_DEST_WIDTH  = 3'd2;
   localparam logic [2:0] REG_DEST_HEIGHT = 3'd3;
   localparam logic [2:0] REG_DEST_COL    = 3'd4;
   localparam logic [2:0] REG_DEST_ROW    = 3'd5;
   localparam logic [2:0] REG_RECT_WIDTH  = 3'd6;
   localparam logic [2:0] REG_RECT_HEIGHT = 3'd7;

   // pixel formats (bytes per pixel)
   localparam logic [FMT_W-1:0] FMT_GRAY  = 3'd1;
   localparam logic [FMT_W-1:0] FMT_GRAYA = 3'd2;
   localparam logic [FMT_W-1:0] FMT_RGB   = 3'd3;
   localparam logic [FMT_W-1:0] FMT_RGBA  = 3'd4;

   // result status
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_FIT  = 2'd2;

   typedef struct packed {
      logic [FMT_W-1:0] sf;
      logic [FMT_W-1:0] df;
      logic [DIM_W-1:0] dw;
      logic [DIM_W-1:0] dh;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic [DIM_W-1:0] rw;
      logic [DIM_W-1:0] rh;
      logic             clr;   // register written: restart rectangle
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic mul;
      logic sum;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

   function automatic logic [FMT_W-1:0] fmt_clamp(input logic [FMT_W-1:0] f);
      logic [FMT_W-1:0] r;
      r = f;
      if (f < FMT_GRAY) begin
         r = FMT_GRAY;
      end else if (f > FMT_RGBA) begin
         r = FMT_RGBA;
      end
      return r;
   endfunction

   function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] d);
      return (d > MAX_DIM) ? MAX_DIM : d;
   endfunction

endpackage

@@ rtl/fcrb_csr.sv @@
// ----------------------------------------------------------------------------
// fcrb_csr
// Configuration registers on the APB-style port, with clamped views.
// ----------------------------------------------------------------------------
module fcrb_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [fcrb_pkg::ADDR_W-1:0]   paddr,
   input  logic [fcrb_pkg::DATA_W-1:0]   pwdata,
   output logic [fcrb_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output fcrb_pkg::cfg_type             cfg
);

   logic [fcrb_pkg::FMT_W-1:0] src_format_ff,  src_format_in;
   logic [fcrb_pkg::FMT_W-1:0] dest_format_ff, dest_format_in;
   logic [fcrb_pkg::DIM_W-1:0] dest_width_ff,  dest_width_in;
   logic [fcrb_pkg::DIM_W-1:0] dest_height_ff, dest_height_in;
   logic [fcrb_pkg::POS_W-1:0] dest_col_ff,    dest_col_in;
   logic [fcrb_pkg::POS_W-1:0] dest_row_ff,    dest_row_in;
   logic [fcrb_pkg::DIM_W-1:0] rect_width_ff,  rect_width_in;
   logic [fcrb_pkg::DIM_W-1:0] rect_height_ff, rect_height_in;
   logic                       wr;
   logic [2:0]                 idx;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;
   assign idx    = paddr[4:2];

   always_comb begin
      src_format_in  = src_format_ff;
      dest_format_in = dest_format_ff;
      dest_width_in  = dest_width_ff;
      dest_height_in = dest_height_ff;
      dest_col_in    = dest_col_ff;
      dest_row_in    = dest_row_ff;
      rect_width_in  = rect_width_ff;
      rect_height_in = rect_height_ff;
      if (wr) begin
         unique case (idx)
            fcrb_pkg::REG_SRC_FORMAT:  src_format_in  = pwdata[fcrb_pkg::FMT_W-1:0];
            fcrb_pkg::REG_DEST_FORMAT: dest_format_in = pwdata[fcrb_pkg::FMT_W-1:0];
            fcrb_pkg::REG_DEST_WIDTH:  dest_width_in  = pwdata[fcrb_pkg::DIM_W-1:0];
            fcrb_pkg::REG_DEST_HEIGHT: dest_height_in = pwdata[fcrb_pkg::DIM_W-1:0];
            fcrb_pkg::REG_DEST_COL:    dest_col_in    = pwdata[fcrb_pkg::POS_W-1:0];
            fcrb_pkg::REG_DEST_ROW:    dest_row_in    = pwdata[fcrb_pkg::POS_W-1:0];
            fcrb_pkg::REG_RECT_WIDTH:  rect_width_in  = pwdata[fcrb_pkg::DIM_W-1:0];
            fcrb_pkg::REG_RECT_HEIGHT: rect_height_in = pwdata[fcrb_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_format_ff  <= fcrb_pkg::FMT_RGBA;
         dest_format_ff <= fcrb_pkg::FMT_RGBA;
         dest_width_ff  <= 13'd1;
         dest_height_ff <= 13'd1;
         dest_col_ff    <= '0;
         dest_row_ff    <= '0;
         rect_width_ff  <= 13'd1;
         rect_height_ff <= 13'd1;
      end else begin
         src_format_ff  <= src_format_in;
         dest_format_ff <= dest_format_in;
         dest_width_ff  <= dest_width_in;
         dest_height_ff <= dest_height_in;
         dest_col_ff    <= dest_col_in;
         dest_row_ff    <= dest_row_in;
         rect_width_ff  <= rect_width_in;
         rect_height_ff <= rect_height_in;
      end
   end

   // readback of the raw register values
   always_comb begin
      prdata = '0;
      unique case (idx)
         fcrb_pkg::REG_SRC_FORMAT:  prdata = 32'(src_format_ff);
         fcrb_pkg::REG_DEST_FORMAT: prdata = 32'(dest_format_ff);
         fcrb_pkg::REG_DEST_WIDTH:  prdata = 32'(dest_width_ff);
         fcrb_pkg::REG_DEST_HEIGHT: prdata = 32'(dest_height_ff);
         fcrb_pkg::REG_DEST_COL:    prdata = 32'(dest_col_ff);
         fcrb_pkg::REG_DEST_ROW:    prdata = 32'(dest_row_ff);
         fcrb_pkg::REG_RECT_WIDTH:  prdata = 32'(rect_width_ff);
         fcrb_pkg::REG_RECT_HEIGHT: prdata = 32'(rect_height_ff);
         default: prdata = '0;
      endcase
   end

   always_comb begin
      cfg.sf  = fcrb_pkg::fmt_clamp(src_format_ff);
      cfg.df  = fcrb_pkg::fmt_clamp(dest_format_ff);
      cfg.dw  = fcrb_pkg::dim_clamp(dest_width_ff);
      cfg.dh  = fcrb_pkg::dim_clamp(dest_height_ff);
      cfg.col = dest_col_ff;
      cfg.row = dest_row_ff;
      cfg.rw  = fcrb_pkg::dim_clamp(rect_width_ff);
      cfg.rh  = fcrb_pkg::dim_clamp(rect_height_ff);
      cfg.clr = wr;
   end

endmodule

@@ rtl/fcrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// fcrb_ctrl
// Sequencer: capture, multiply, add, then hand off to the output register.
// ----------------------------------------------------------------------------
module fcrb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fcrb_pkg::stat_type stat,
   output fcrb_pkg::cmd_type  cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_SUM  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.mul     = 1'b0;
      cmd.sum     = 1'b0;
      cmd.load    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            // wait for the output register to free up
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/fcrb_dp.sv @@
// ----------------------------------------------------------------------------
// fcrb_dp
// Datapath: position counters, fit check, color conversion, offset math,
// output register.
// ----------------------------------------------------------------------------
module fcrb_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  fcrb_pkg::cfg_type           cfg,
   input  fcrb_pkg::cmd_type           cmd,
   output fcrb_pkg::stat_type          stat,
   input  logic [fcrb_pkg::CH_W-1:0]   in_ch0,
   input  logic [fcrb_pkg::CH_W-1:0]   in_ch1,
   input  logic [fcrb_pkg::CH_W-1:0]   in_ch2,
   input  logic [fcrb_pkg::CH_W-1:0]   in_ch3,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [fcrb_pkg::OFF_W-1:0]  dest_offset,
   output logic [fcrb_pkg::CH_W-1:0]   out_ch0,
   output logic [fcrb_pkg::CH_W-1:0]   out_ch1,
   output logic [fcrb_pkg::CH_W-1:0]   out_ch2,
   output logic [fcrb_pkg::CH_W-1:0]   out_ch3,
   output logic                        write_enable,
   output logic [1:0]                  status,
   output logic                        last
);

   localparam int CW = fcrb_pkg::CH_W;
   localparam int OW = fcrb_pkg::OFF_W;
   localparam int DW = fcrb_pkg::DIM_W;
   localparam int PW = fcrb_pkg::POS_W;

   // position in the rectangle
   logic [PW-1:0] col_cnt_ff, col_cnt_in;
   logic [PW-1:0] row_cnt_ff, row_cnt_in;

   // capture stage
   logic [CW-1:0] c0_ff, c1_ff, c2_ff, c3_ff;
   logic [DW-1:0] row_abs_ff, col_abs_ff;
   logic [1:0]    st_ff, st_in;
   logic          last_ff, last_in;

   // multiply stage
   logic [OW-1:0] prod_ff;
   logic [CW-1:0] ch0_ff, ch1_ff, ch2_ff, ch3_ff;
   logic [CW-1:0] ch0_in, ch1_in, ch2_in, ch3_in;

   // add stage
   logic [OW-1:0] lin_ff;

   // output register
   logic          ovld_ff, ovld_in;
   logic [OW-1:0] off_ff, off_in;
   logic [CW-1:0] o0_ff, o1_ff, o2_ff, o3_ff;
   logic          we_ff;
   logic [1:0]    ost_ff;
   logic          olast_ff;

   logic          col_end, row_end;
   logic [DW:0]   col_reach, row_reach;
   logic [9:0]    rgb_sum;
   logic [18:0]   gray_mul;
   logic [CW-1:0] gray, alpha, red, green, blue;
   logic          ok;

   // ---- fit check and counter advance ----
   assign col_end   = ({1'b0, col_cnt_ff} + 13'd1) >= cfg.rw;
   assign row_end   = ({1'b0, row_cnt_ff} + 13'd1) >= cfg.rh;
   assign col_reach = {2'b00, cfg.col} + {1'b0, cfg.rw};
   assign row_reach = {2'b00, cfg.row} + {1'b0, cfg.rh};

   always_comb begin
      if (cfg.rw == '0 || cfg.rh == '0) begin
         st_in = fcrb_pkg::ST_ZERO;
      end else if (col_reach > {1'b0, cfg.dw} || row_reach > {1'b0, cfg.dh}) begin
         st_in = fcrb_pkg::ST_FIT;
      end else begin
         st_in = fcrb_pkg::ST_OK;
      end
      last_in = col_end & row_end;
   end

   always_comb begin
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (cfg.clr) begin
         col_cnt_in = '0;
         row_cnt_in = '0;
      end else if (cmd.capture && st_in == fcrb_pkg::ST_OK) begin
         if (col_end) begin
            col_cnt_in = '0;
            row_cnt_in = row_end ? '0 : row_cnt_ff + 12'd1;
         end else begin
            col_cnt_in = col_cnt_ff + 12'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         c0_ff      <= in_ch0;
         c1_ff      <= in_ch1;
         c2_ff      <= in_ch2;
         c3_ff      <= in_ch3;
         row_abs_ff <= {1'b0, cfg.row} + {1'b0, row_cnt_ff};
         col_abs_ff <= {1'b0, cfg.col} + {1'b0, col_cnt_ff};
         st_ff      <= st_in;
         last_ff    <= last_in;
      end
   end

   // ---- color conversion ----
   assign rgb_sum  = 10'(c0_ff) + 10'(c1_ff) + 10'(c2_ff);
   assign gray_mul = 19'(rgb_sum) * 19'(fcrb_pkg::GRAY_RECIP);

   always_comb begin
      if (cfg.sf <= fcrb_pkg::FMT_GRAYA) begin
         gray  = c0_ff;
         alpha = (cfg.sf == fcrb_pkg::FMT_GRAYA) ? c1_ff : fcrb_pkg::OPAQUE;
         red   = c0_ff;
         green = c0_ff;
         blue  = c0_ff;
      end else begin
         gray  = gray_mul[fcrb_pkg::GRAY_SHIFT +: CW];
         alpha = (cfg.sf == fcrb_pkg::FMT_RGBA) ? c3_ff : fcrb_pkg::OPAQUE;
         red   = c0_ff;
         green = c1_ff;
         blue  = c2_ff;
      end
      if (cfg.df <= fcrb_pkg::FMT_GRAYA) begin
         ch0_in = gray;
         ch1_in = (cfg.df == fcrb_pkg::FMT_GRAYA) ? alpha : '0;
         ch2_in = '0;
         ch3_in = '0;
      end else begin
         ch0_in = red;
         ch1_in = green;
         ch2_in = blue;
         ch3_in = (cfg.df == fcrb_pkg::FMT_RGBA) ? alpha : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= OW'(row_abs_ff) * OW'(cfg.dw);
         ch0_ff  <= ch0_in;
         ch1_ff  <= ch1_in;
         ch2_ff  <= ch2_in;
         ch3_ff  <= ch3_in;
      end
      if (cmd.sum) begin
         lin_ff <= prod_ff + OW'(col_abs_ff);
      end
   end

   // ---- byte offset: pixel index times bytes per pixel ----
   always_comb begin
      case (cfg.df)
         fcrb_pkg::FMT_GRAY:  off_in = lin_ff;
         fcrb_pkg::FMT_GRAYA: off_in = lin_ff << 1;
         fcrb_pkg::FMT_RGB:   off_in = lin_ff + (lin_ff << 1);
         default:             off_in = lin_ff << 2;
      endcase
   end

   // ---- output register ----
   assign ok            = (st_ff == fcrb_pkg::ST_OK);
   assign stat.out_free = ~ovld_ff | rsp_ready;

   always_comb begin
      ovld_in = ovld_ff;
      if (cmd.load) begin
         ovld_in = 1'b1;
      end else if (rsp_ready) begin
         ovld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else begin
         ovld_ff <= ovld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         off_ff   <= ok ? off_in : '0;
         o0_ff    <= ok ? ch0_ff : '0;
         o1_ff    <= ok ? ch1_ff : '0;
         o2_ff    <= ok ? ch2_ff : '0;
         o3_ff    <= ok ? ch3_ff : '0;
         we_ff    <= ok;
         ost_ff   <= st_ff;
         olast_ff <= ok & last_ff;
      end
   end

   assign rsp_valid    = ovld_ff;
   assign dest_offset  = off_ff;
   assign out_ch0      = o0_ff;
   assign out_ch1      = o1_ff;
   assign out_ch2      = o2_ff;
   assign out_ch3      = o3_ff;
   assign write_enable = we_ff;
   assign status       = ost_ff;
   assign last         = olast_ff;

endmodule

@@ rtl/format_converting_rect_blit.sv @@
// ----------------------------------------------------------------------------
// format_converting_rect_blit
// Converts a raster-order pixel stream of a rectangle to the destination
// pixel format and tags each word with its destination byte offset.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one source pixel word (in_ch0..3) per handshake, in raster
//    order over the rectangle. rsp channel: one result word per input word.
//  - Config via the APB port (register i at byte 4*i); write only while the
//    block is idle. Any write restarts the rectangle at its top left pixel.
//  - Result path: capture at the accept edge, then multiply row by width, add
//    column, scale by bytes per pixel into the output reg; the load waits
//    while the output register holds a result that rsp_ready does not take.
//  - The sequencer handles one word at a time: a new word is taken only after
//    the previous one is loaded into the output register.
//  - The output register decouples the sides: the next word is taken while
//    a result still waits. If rsp_ready stays low, the following result waits
//    in the datapath and req_ready stays low until the output register frees.
//  - Bad geometry (zero size, or not fitting the destination) yields a word
//    with write_enable low, status set, all other fields zero; the position
//    counters hold.
//  - Reset: registers return to RGBA->RGBA, 1x1 rectangle at origin; counters
//    and the output valid clear.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module format_converting_rect_blit (
   input  logic                         clock,
   input  logic                         reset,
   // input pixels
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [fcrb_pkg::CH_W-1:0]    req_in_ch0,
   input  logic [fcrb_pkg::CH_W-1:0]    req_in_ch1,
   input  logic [fcrb_pkg::CH_W-1:0]    req_in_ch2,
   input  logic [fcrb_pkg::CH_W-1:0]    req_in_ch3,
   // converted pixels
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [fcrb_pkg::OFF_W-1:0]   rsp_dest_offset,
   output logic [fcrb_pkg::CH_W-1:0]    rsp_out_ch0,
   output logic [fcrb_pkg::CH_W-1:0]    rsp_out_ch1,
   output logic [fcrb_pkg::CH_W-1:0]    rsp_out_ch2,
   output logic [fcrb_pkg::CH_W-1:0]    rsp_out_ch3,
   output logic                         rsp_write_enable,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_last,
   // configuration
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [fcrb_pkg::ADDR_W-1:0]  paddr,
   input  logic [fcrb_pkg::DATA_W-1:0]  pwdata,
   output logic [fcrb_pkg::DATA_W-1:0]  prdata,
   output logic                         pready
);

   fcrb_pkg::cfg_type  cfg;
   fcrb_pkg::cmd_type  cmd;
   fcrb_pkg::stat_type stat;
   logic               rsp_ok;
   logic               rsp_err;

   // register file; clamps formats to 1..4 and sizes to the max dimension
   fcrb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: one word in flight through capture/mul/sum/done
   fcrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // counters, conversion, offset arithmetic and the output register
   fcrb_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .cmd          (cmd),
      .stat         (stat),
      .in_ch0       (req_in_ch0),
      .in_ch1       (req_in_ch1),
      .in_ch2       (req_in_ch2),
      .in_ch3       (req_in_ch3),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .dest_offset  (rsp_dest_offset),
      .out_ch0      (rsp_out_ch0),
      .out_ch1      (rsp_out_ch1),
      .out_ch2      (rsp_out_ch2),
      .out_ch3      (rsp_out_ch3),
      .write_enable (rsp_write_enable),
      .status       (rsp_status),
      .last         (rsp_last)
   );

   assign rsp_ok  = (rsp_status == fcrb_pkg::ST_OK);
   assign rsp_err = rsp_valid && !rsp_ok;

   // one word in flight: intake closes right after an accept
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // write enable exactly on good status
   `ASSERT_IMPLIES(a_we_matches_status, clock, reset, rsp_valid, rsp_write_enable == rsp_ok)
   // error words carry no offset and no end marker
   `ASSERT_IMPLIES(a_error_word_clean, clock, reset, rsp_err, rsp_dest_offset == '0 && !rsp_last)

endmodule

@@ tb/tb_format_converting_rect_blit.sv @@
// ----------------------------------------------------------------------------
// tb_format_converting_rect_blit
// Streams source pixels through the blitter under many register settings and
// checks every result word, field by field, against an in-bench predictor of
// the format conversion, offset math, geometry errors and raster position.
// ----------------------------------------------------------------------------
module tb_format_converting_rect_blit;

   localparam int STALL_CYCLES   = 150;   // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
   localparam int ITEM_TARGET    = 1550;
   localparam int QUIET_PHASE    = 3;     // no idling on either side
   localparam int HOLD_PHASE     = 5;     // receiver holds off, block backs up
   localparam int PAUSE_PHASE    = 8;     // sender pauses until fully drained

   typedef struct packed {
      logic [fcrb_pkg::CH_W-1:0] ch3;
      logic [fcrb_pkg::CH_W-1:0] ch2;
      logic [fcrb_pkg::CH_W-1:0] ch1;
      logic [fcrb_pkg::CH_W-1:0] ch0;
   } pixel_type;

   typedef struct packed {
      logic [fcrb_pkg::OFF_W-1:0] offset;
      logic [fcrb_pkg::CH_W-1:0]  ch0;
      logic [fcrb_pkg::CH_W-1:0]  ch1;
      logic [fcrb_pkg::CH_W-1:0]  ch2;
      logic [fcrb_pkg::CH_W-1:0]  ch3;
      logic                       we;
      logic [1:0]                 status;
      logic                       is_last;
   } blit_word_type;

   // ---------------------------------------------------------------------
   // DUT signals; every input starts at a known value
   // ---------------------------------------------------------------------
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [fcrb_pkg::CH_W-1:0]     req_in_ch0 = '0;
   logic [fcrb_pkg::CH_W-1:0]     req_in_ch1 = '0;
   logic [fcrb_pkg::CH_W-1:0]     req_in_ch2 = '0;
   logic [fcrb_pkg::CH_W-1:0]     req_in_ch3 = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [fcrb_pkg::OFF_W-1:0]    rsp_dest_offset;
   logic [fcrb_pkg::CH_W-1:0]     rsp_out_ch0;
   logic [fcrb_pkg::CH_W-1:0]     rsp_out_ch1;
   logic [fcrb_pkg::CH_W-1:0]     rsp_out_ch2;
   logic [fcrb_pkg::CH_W-1:0]     rsp_out_ch3;
   logic                          rsp_write_enable;
   logic [1:0]                    rsp_status;
   logic                          rsp_last;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [fcrb_pkg::ADDR_W-1:0]   paddr = '0;
   logic [fcrb_pkg::DATA_W-1:0]   pwdata = '0;
   logic [fcrb_pkg::DATA_W-1:0]   prdata;
   logic                          pready;

   // ---------------------------------------------------------------------
   // Predictor state: register shadow (reset values) and raster position
   // ---------------------------------------------------------------------
   logic [fcrb_pkg::FMT_W-1:0] cfg_src_fmt  = fcrb_pkg::FMT_RGBA;
   logic [fcrb_pkg::FMT_W-1:0] cfg_dst_fmt  = fcrb_pkg::FMT_RGBA;
   logic [fcrb_pkg::DIM_W-1:0] cfg_dest_w   = 13'd1;
   logic [fcrb_pkg::DIM_W-1:0] cfg_dest_h   = 13'd1;
   logic [fcrb_pkg::POS_W-1:0] cfg_col      = '0;
   logic [fcrb_pkg::POS_W-1:0] cfg_row      = '0;
   logic [fcrb_pkg::DIM_W-1:0] cfg_rect_w   = 13'd1;
   logic [fcrb_pkg::DIM_W-1:0] cfg_rect_h   = 13'd1;
   int unsigned                col_pos      = 0;
   int unsigned                row_pos      = 0;

   // ---------------------------------------------------------------------
   // Bench bookkeeping
   // ---------------------------------------------------------------------
   pixel_type     source_pixels [$];   // words waiting to be offered
   blit_word_type pending_words [$];   // predicted results, oldest first
   int unsigned   words_sent    = 0;   // pushed into source_pixels
   int unsigned   words_taken   = 0;   // accepted by the block
   int unsigned   mismatches    = 0;
   int unsigned   idle_cycles   = 0;
   int unsigned   src_idle_pct  = 25;
   int unsigned   sink_idle_pct = 25;
   logic          src_pause     = 1'b0;
   logic          req_taken     = 1'b0;
   int unsigned   hold_token    = 0;   // bumped by stimulus to request a hold
   int unsigned   hold_seen     = 0;
   int unsigned   hold_left     = 0;

   format_converting_rect_blit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_ch0       (req_in_ch0),
      .req_in_ch1       (req_in_ch1),
      .req_in_ch2       (req_in_ch2),
      .req_in_ch3       (req_in_ch3),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_dest_offset  (rsp_dest_offset),
      .rsp_out_ch0      (rsp_out_ch0),
      .rsp_out_ch1      (rsp_out_ch1),
      .rsp_out_ch2      (rsp_out_ch2),
      .rsp_out_ch3      (rsp_out_ch3),
      .rsp_write_enable (rsp_write_enable),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor: converts one accepted source pixel and advances the raster
   // position. Geometry errors leave the position where it is.
   // ---------------------------------------------------------------------
   function automatic blit_word_type convert_pixel(input pixel_type px);
      int unsigned   sf, df, dw, dh, rw, rh;
      int unsigned   gray, alpha, r, g, b, offs;
      blit_word_type w;
      w  = '0;
      // out-of-range formats fold to the nearest legal one
      sf = 32'((cfg_src_fmt < fcrb_pkg::FMT_GRAY) ? fcrb_pkg::FMT_GRAY :
               (cfg_src_fmt > fcrb_pkg::FMT_RGBA) ? fcrb_pkg::FMT_RGBA : cfg_src_fmt);
      df = 32'((cfg_dst_fmt < fcrb_pkg::FMT_GRAY) ? fcrb_pkg::FMT_GRAY :
               (cfg_dst_fmt > fcrb_pkg::FMT_RGBA) ? fcrb_pkg::FMT_RGBA : cfg_dst_fmt);
      // dimensions saturate at the largest supported size
      dw = 32'((cfg_dest_w > fcrb_pkg::MAX_DIM) ? fcrb_pkg::MAX_DIM : cfg_dest_w);
      dh = 32'((cfg_dest_h > fcrb_pkg::MAX_DIM) ? fcrb_pkg::MAX_DIM : cfg_dest_h);
      rw = 32'((cfg_rect_w > fcrb_pkg::MAX_DIM) ? fcrb_pkg::MAX_DIM : cfg_rect_w);
      rh = 32'((cfg_rect_h > fcrb_pkg::MAX_DIM) ? fcrb_pkg::MAX_DIM : cfg_rect_h);

      // zero size wins over the fit test
      if (rw == 0 || rh == 0) begin
         w.status = fcrb_pkg::ST_ZERO;
         return w;
      end
      if (32'(cfg_col) + rw > dw || 32'(cfg_row) + rh > dh) begin
         w.status = fcrb_pkg::ST_FIT;
         return w;
      end

      if (sf <= 32'(fcrb_pkg::FMT_GRAYA)) begin
         gray  = 32'(px.ch0);
         alpha = 32'((sf == 32'(fcrb_pkg::FMT_GRAYA)) ? px.ch1 : fcrb_pkg::OPAQUE);
         r = 32'(px.ch0);
         g = 32'(px.ch0);
         b = 32'(px.ch0);
      end else begin
         r = 32'(px.ch0);
         g = 32'(px.ch1);
         b = 32'(px.ch2);
         gray  = (r + g + b) / 3;
         alpha = 32'((sf == 32'(fcrb_pkg::FMT_RGBA)) ? px.ch3 : fcrb_pkg::OPAQUE);
      end

      // channels past the destination pixel size stay zero
      if (df <= 32'(fcrb_pkg::FMT_GRAYA)) begin
         w.ch0 = 8'(gray);
         if (df == 32'(fcrb_pkg::FMT_GRAYA)) w.ch1 = 8'(alpha);
      end else begin
         w.ch0 = 8'(r);
         w.ch1 = 8'(g);
         w.ch2 = 8'(b);
         if (df == 32'(fcrb_pkg::FMT_RGBA)) w.ch3 = 8'(alpha);
      end

      offs      = ((32'(cfg_row) + row_pos) * dw + 32'(cfg_col) + col_pos) * df;
      w.offset  = offs[fcrb_pkg::OFF_W-1:0];
      w.we      = 1'b1;
      w.status  = fcrb_pkg::ST_OK;
      w.is_last = (col_pos + 1 >= rw) && (row_pos + 1 >= rh);

      if (col_pos + 1 >= rw) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= rh) ? 0 : row_pos + 1;
      end else begin
         col_pos++;
      end
      return w;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         mismatches++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: offers queued pixels at the falling edge. A word stays put
   // until taken; a new one is only picked once the previous one went.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      pixel_type px;
      if (!req_valid || req_taken) begin
         if (source_pixels.size() != 0 && !src_pause &&
             $urandom_range(99, 0) >= src_idle_pct) begin
            px = source_pixels.pop_front();
            req_valid  <= 1'b1;
            req_in_ch0 <= px.ch0;
            req_in_ch1 <= px.ch1;
            req_in_ch2 <= px.ch2;
            req_in_ch3 <= px.ch3;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure, plus a long hold when stimulus asks
   always @(negedge clock) begin
      if (hold_seen != hold_token) begin
         hold_seen <= hold_token;
         hold_left <= STALL_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= sink_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks results first, then records the accepted pixel, so a
   // word accepted at this edge can never meet its own expectation here.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      blit_word_type want;
      pixel_type     px;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_words.size() == 0) begin
               mismatches++;
               $error("result word with no expectation pending");
            end else begin
               want = pending_words.pop_front();
               check_field("dest_offset",  want.offset,  rsp_dest_offset);
               check_field("out_ch0",      want.ch0,     rsp_out_ch0);
               check_field("out_ch1",      want.ch1,     rsp_out_ch1);
               check_field("out_ch2",      want.ch2,     rsp_out_ch2);
               check_field("out_ch3",      want.ch3,     rsp_out_ch3);
               check_field("write_enable", want.we,      rsp_write_enable);
               check_field("status",       want.status,  rsp_status);
               check_field("last",         want.is_last, rsp_last);
            end
         end
         if (req_valid && req_ready) begin
            px = {req_in_ch3, req_in_ch2, req_in_ch1, req_in_ch0};
            pending_words.push_back(convert_pixel(px));
            words_taken++;
         end
      end
      req_taken <= req_valid && req_ready;
   end

   // Watchdog: any handshake on any port counts as progress
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_format_converting_rect_blit: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Waits until every pushed word was taken and answered, then lets the
   // pipeline settle for its latency.
   task automatic drain();
      while (words_taken != words_sent || pending_words.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // APB write: setup cycle, then access cycle; pready is tied high.
   task automatic csr_write(input logic [2:0] idx, input int unsigned value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         fcrb_pkg::REG_SRC_FORMAT:  cfg_src_fmt = value[fcrb_pkg::FMT_W-1:0];
         fcrb_pkg::REG_DEST_FORMAT: cfg_dst_fmt = value[fcrb_pkg::FMT_W-1:0];
         fcrb_pkg::REG_DEST_WIDTH:  cfg_dest_w  = value[fcrb_pkg::DIM_W-1:0];
         fcrb_pkg::REG_DEST_HEIGHT: cfg_dest_h  = value[fcrb_pkg::DIM_W-1:0];
         fcrb_pkg::REG_DEST_COL:    cfg_col     = value[fcrb_pkg::POS_W-1:0];
         fcrb_pkg::REG_DEST_ROW:    cfg_row     = value[fcrb_pkg::POS_W-1:0];
         fcrb_pkg::REG_RECT_WIDTH:  cfg_rect_w  = value[fcrb_pkg::DIM_W-1:0];
         fcrb_pkg::REG_RECT_HEIGHT: cfg_rect_h  = value[fcrb_pkg::DIM_W-1:0];
         default: ;
      endcase
      // any write restarts the rectangle
      col_pos = 0;
      row_pos = 0;
   endtask

   // Drains, then rewrites the whole register set.
   task automatic set_geometry(input int unsigned sf, input int unsigned df,
                               input int unsigned dw, input int unsigned dh,
                               input int unsigned dc, input int unsigned dr,
                               input int unsigned rw, input int unsigned rh);
      drain();
      csr_write(fcrb_pkg::REG_SRC_FORMAT,  sf);
      csr_write(fcrb_pkg::REG_DEST_FORMAT, df);
      csr_write(fcrb_pkg::REG_DEST_WIDTH,  dw);
      csr_write(fcrb_pkg::REG_DEST_HEIGHT, dh);
      csr_write(fcrb_pkg::REG_DEST_COL,    dc);
      csr_write(fcrb_pkg::REG_DEST_ROW,    dr);
      csr_write(fcrb_pkg::REG_RECT_WIDTH,  rw);
      csr_write(fcrb_pkg::REG_RECT_HEIGHT, rh);
   endtask

   task automatic push_pixel(input logic [7:0] c0, input logic [7:0] c1,
                             input logic [7:0] c2, input logic [7:0] c3);
      source_pixels.push_back({c3, c2, c1, c0});
      words_sent++;
   endtask

   task automatic push_random(input int unsigned n);
      repeat (n) begin
         push_pixel(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                    8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
      end
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      int unsigned phase, sel, n, first;
      int unsigned sf, df, dw, dh, dc, dr, rw, rh;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // reset settings: RGBA to RGBA, 1x1 at the origin
      push_pixel(8'h00, 8'h00, 8'h00, 8'h00);
      push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      // color to gray, sum just under full scale
      set_geometry(fcrb_pkg::FMT_RGB, fcrb_pkg::FMT_GRAY, 4, 4, 0, 0, 1, 1);
      push_pixel(8'hFF, 8'hFF, 8'hFE, 8'h07);
      // RGBA to gray+alpha, alpha passes
      set_geometry(fcrb_pkg::FMT_RGBA, fcrb_pkg::FMT_GRAYA, 4, 4, 1, 1, 1, 1);
      push_pixel(8'hFF, 8'hFF, 8'hFF, 8'h5A);
      // gray to RGBA: color copies gray, alpha goes opaque
      set_geometry(fcrb_pkg::FMT_GRAY, fcrb_pkg::FMT_RGBA, 4, 4, 3, 3, 1, 1);
      push_pixel(8'h81, 8'h7E, 8'h33, 8'h44);
      // gray+alpha to RGB: alpha dropped
      set_geometry(fcrb_pkg::FMT_GRAYA, fcrb_pkg::FMT_RGB, 4, 4, 2, 0, 1, 1);
      push_pixel(8'hC3, 8'h3C, 8'hA5, 8'h5A);
      // equal formats copy unchanged
      set_geometry(fcrb_pkg::FMT_GRAYA, fcrb_pkg::FMT_GRAYA, 4, 4, 0, 2, 1, 1);
      push_pixel(8'h96, 8'h69, 8'h11, 8'h22);
      // out-of-range formats: low folds to gray, high folds to RGBA
      set_geometry(0, 7, 4, 4, 0, 0, 1, 1);
      push_pixel(8'h12, 8'h34, 8'h56, 8'h78);
      set_geometry(5, 0, 4, 4, 0, 0, 1, 1);
      push_pixel(8'h9A, 8'hBC, 8'hDE, 8'hF0);
      // zero width
      set_geometry(fcrb_pkg::FMT_RGBA, fcrb_pkg::FMT_RGBA, 8, 8, 0, 0, 0, 3);
      push_pixel(8'h01, 8'h02, 8'h03, 8'h04);
      // zero height reported ahead of a failed fit
      set_geometry(fcrb_pkg::FMT_RGBA, fcrb_pkg::FMT_RGBA, 8, 8, 4095, 4095, 2, 0);
      push_pixel(8'h05, 8'h06, 8'h07, 8'h08);
      // overruns the right edge, then the bottom edge
      set_geometry(fcrb_pkg::FMT_RGBA, fcrb_pkg::FMT_RGBA, 8, 8, 7, 0, 2, 1);
      push_pixel(8'h09, 8'h0A, 8'h0B, 8'h0C);
      set_geometry(fcrb_pkg::FMT_RGBA, fcrb_pkg::FMT_RGBA, 8, 8, 0, 7, 1, 2);
      push_pixel(8'h0D, 8'h0E, 8'h0F, 8'h10);
      // exact fit in the bottom right corner
      set_geometry(fcrb_pkg::FMT_RGB, fcrb_pkg::FMT_RGB, 8, 8, 6, 7, 2, 1);
      push_pixel(8'h11, 8'h22, 8'h33, 8'h44);
      push_pixel(8'h55, 8'h66, 8'h77, 8'h88);
      // oversize dimensions saturate, full-width rectangle fits
      set_geometry(fcrb_pkg::FMT_RGBA, fcrb_pkg::FMT_RGBA, 8191, 8191, 0, 0, 8191, 1);
      push_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
      push_pixel(8'h55, 8'hAA, 8'h55, 8'hAA);
      // largest offset the geometry allows
      set_geometry(fcrb_pkg::FMT_RGBA, fcrb_pkg::FMT_RGBA, 4096, 4096, 4095, 4095, 1, 1);
      push_pixel(8'hFE, 8'hFD, 8'hFC, 8'hFB);
      // 2x2 rectangle, then wrap to its top left
      set_geometry(fcrb_pkg::FMT_RGBA, fcrb_pkg::FMT_RGB, 5, 4, 3, 2, 2, 2);
      push_random(5);

      // --- random part ---
      phase = 0;
      while (words_sent < ITEM_TARGET) begin
         phase++;
         sel = $urandom_range(99, 0);
         if (sel < 75) begin
            // well-formed: whole rectangles, sometimes cut short
            sf = $urandom_range(4, 1);
            df = $urandom_range(4, 1);
            if ($urandom_range(9, 0) == 0) sf = $urandom_range(7, 0);
            if ($urandom_range(9, 0) == 0) df = $urandom_range(7, 0);
            rw = ($urandom_range(9, 0) == 0) ? $urandom_range(64, 1) : $urandom_range(6, 1);
            rh = ($urandom_range(9, 0) == 0) ? $urandom_range(16, 1) : $urandom_range(5, 1);
            dw = rw + $urandom_range(10, 0);
            dh = rh + $urandom_range(10, 0);
            if ($urandom_range(7, 0) == 0) begin
               dw = $urandom_range(4096, rw);
               dh = $urandom_range(4096, rh);
            end
            dc = $urandom_range(dw - rw, 0);
            dr = $urandom_range(dh - rh, 0);
            n  = rw * rh * ((rw * rh > 60) ? 1 : $urandom_range(3, 1));
            if ($urandom_range(4, 0) == 0) n = $urandom_range(n, 1);
         end else if (sel < 87) begin
            // far corner of a big destination, saturated sizes
            sf = $urandom_range(4, 1);
            df = $urandom_range(4, 1);
            rw = $urandom_range(4, 1);
            rh = $urandom_range(3, 1);
            dw = $urandom_range(8191, 4090);
            dh = $urandom_range(8191, 4090);
            dc = $urandom_range(4095, 4090 - rw);
            dr = $urandom_range(4095, 4090 - rh);
            if ($urandom_range(3, 0) == 0) begin
               rw = $urandom_range(8191, 4096);
               dc = $urandom_range(1, 0);
            end
            n = (rw <= 4) ? rw * rh * $urandom_range(2, 1) : $urandom_range(10, 2);
         end else begin
            // raw register values: mostly error geometry
            sf = $urandom_range(7, 0);
            df = $urandom_range(7, 0);
            dw = $urandom_range(8191, 0);
            dh = $urandom_range(8191, 0);
            dc = $urandom_range(4095, 0);
            dr = $urandom_range(4095, 0);
            rw = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8191, 0);
            rh = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8191, 0);
            n  = $urandom_range(10, 1);
         end

         if (phase == QUIET_PHASE) begin
            n = (n < 150) ? 150 : n;
         end else if (phase == HOLD_PHASE || phase == PAUSE_PHASE) begin
            n = (n < 40) ? 40 : n;
         end

         set_geometry(sf, df, dw, dh, dc, dr, rw, rh);
         src_idle_pct  = (phase == QUIET_PHASE) ? 0 : 25;
         sink_idle_pct = (phase == QUIET_PHASE) ? 0 : 25;
         first = words_sent;
         push_random(n);

         if (phase == HOLD_PHASE) begin
            // receiver stops while the sender keeps offering words
            while (words_taken < first + 2) @(negedge clock);
            hold_token++;
         end else if (phase == PAUSE_PHASE) begin
            while (words_taken < first + n / 2) @(negedge clock);
            src_pause = 1'b1;
            while (pending_words.size() != 0 || req_valid) @(negedge clock);
            repeat (3) @(negedge clock);
            src_pause = 1'b0;
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("tb_format_converting_rect_blit: clean");
      end else begin
         $display("tb_format_converting_rect_blit: errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/fcrb_pkg.sv
rtl/fcrb_csr.sv
rtl/fcrb_ctrl.sv
rtl/fcrb_dp.sv
rtl/format_converting_rect_blit.sv
tb/tb_format_converting_rect_blit.sv
